// ===== rtl/sqm_pkg.sv =====
// Shared types and codes for the sorted max-priority queue.
// No dependencies; used by every module in rtl/.
package sqm_pkg;

  // Width of one stored entry and of the value field
  localparam int unsigned ValueWidth = 32;
  // Width of the reported entry count
  localparam int unsigned CountOutWidth = 5;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                          command;
    logic signed [ValueWidth-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0]  max_value;
    status_e                       status;
    logic [CountOutWidth-1:0]      entry_count;
    logic                          is_empty;
  } out_item_t;

  // Per-item operation broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

// ===== rtl/sorted_max_priority_queue_core.sv =====
// Top level of the sorted max-priority queue: chain of sqm_cell entries,
// occupancy counter and registered result stage. Depends on sqm_pkg, sqm_cell.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+-------------------------------
//  in      | in_valid_i | in_stall_o  | in_item_i  (sqm_pkg::in_item_t)
//  out     | out_valid_o| out_stall_i | out_item_o (sqm_pkg::out_item_t)
//
// Each item is applied to all cells in the cycle it is accepted, so one item
// per cycle is taken while in_stall_o is low; its result shows in the next
// cycle from the output register; the cell chain shifts in a single step.
// Reset clears the occupancy and the output valid; entries need no reset.
// While a result waits under out_stall_i, in_stall_o holds off new items.
module sorted_max_priority_queue_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sqm_pkg::in_item_t     in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sqm_pkg::out_item_t    out_item_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]          count_q, count_d;
  logic                   accept;
  logic                   full, empty;
  sqm_pkg::cell_ctrl_t    ctrl;
  sqm_pkg::out_item_t     res_d, res_q;
  logic                   out_valid_q;
  logic [CW+4:0]          count_wide;

  logic signed [sqm_pkg::ValueWidth-1:0] entry [CAPACITY];
  logic                                  ge    [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(CAPACITY));
  assign empty      = (count_q == '0);

  // Build the cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                                  prev_ge;
    logic signed [sqm_pkg::ValueWidth-1:0] prev_entry;
    logic signed [sqm_pkg::ValueWidth-1:0] next_entry;

    if (i == 0) begin : g_head
      assign prev_ge    = 1'b1;
      assign prev_entry = in_item_i.value;
    end else begin : g_body
      assign prev_ge    = ge[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = entry[i];
    end else begin : g_mid
      assign next_entry = entry[i+1];
    end

    sqm_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .cell_valid_i (count_q > CW'(i)),
      .new_value_i  (in_item_i.value),
      .prev_ge_i    (prev_ge),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .ge_o         (ge[i]),
      .entry_o      (entry[i])
    );
  end

  // Decode the command, gate on full/empty, form the result
  always_comb begin
    ctrl          = '0;
    count_d       = count_q;
    res_d.max_value = '0;
    res_d.status    = sqm_pkg::ST_OK;
    unique case (in_item_i.command)
      sqm_pkg::CMD_ENQ: begin
        if (full) begin
          res_d.status = sqm_pkg::ST_OVERFLOW;
        end else begin
          ctrl.enq = accept;
          count_d  = count_q + CW'(1);
        end
      end
      sqm_pkg::CMD_DEQ: begin
        if (empty) begin
          res_d.status = sqm_pkg::ST_UNDERFLOW;
        end else begin
          ctrl.deq        = accept;
          res_d.max_value = entry[0];
          count_d         = count_q - CW'(1);
        end
      end
      default: begin
        res_d.status = sqm_pkg::ST_OK;
      end
    endcase
    count_wide        = (CW+5)'(count_d);
    res_d.entry_count = count_wide[sqm_pkg::CountOutWidth-1:0];
    res_d.is_empty    = (count_d == '0);
  end

  // Occupancy and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

endmodule

// ===== rtl/sqm_cell.sv =====
// One storage cell of the sorted chain: holds one entry, compares it against
// the incoming value and shifts with its neighbors. Depends on sqm_pkg.
module sqm_cell (
  input  logic                                    clk_i,
  input  sqm_pkg::cell_ctrl_t                     ctrl_i,
  input  logic                                    cell_valid_i,
  input  logic signed [sqm_pkg::ValueWidth-1:0]   new_value_i,
  input  logic                                    prev_ge_i,
  input  logic signed [sqm_pkg::ValueWidth-1:0]   prev_entry_i,
  input  logic signed [sqm_pkg::ValueWidth-1:0]   next_entry_i,
  output logic                                    ge_o,
  output logic signed [sqm_pkg::ValueWidth-1:0]   entry_o
);

  logic signed [sqm_pkg::ValueWidth-1:0] entry_q, entry_d;

  // Keep position: held entry is valid and not below the new value
  assign ge_o    = cell_valid_i && (entry_q >= new_value_i);
  assign entry_o = entry_q;

  // Insert shifts down past the insertion point; removal shifts up
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq && !ge_o) begin
      entry_d = prev_ge_i ? new_value_i : prev_entry_i;
    end else if (ctrl_i.deq) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/sqm_checker.sv =====
// Port-level checks for the sorted max-priority queue, bound to the top level.
// Depends on sqm_pkg and sorted_max_priority_queue_core.
module sqm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input sqm_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sqm_pkg::out_item_t out_item_o
);

  // Empty flag implies a zero count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_empty |-> out_item_o.entry_count == '0)
    else $error("is_empty with nonzero entry_count");

  // Underflow leaves the queue empty and returns zero
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == sqm_pkg::ST_UNDERFLOW
      |-> out_item_o.is_empty && out_item_o.max_value == '0)
    else $error("underflow result inconsistent");

  // Overflow leaves the queue non-empty and returns zero
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == sqm_pkg::ST_OVERFLOW
      |-> !out_item_o.is_empty && out_item_o.max_value == '0)
    else $error("overflow result inconsistent");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // An accepted item shows a result next cycle whose status fits its command
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o &&
      (($past(in_item_i.command) == sqm_pkg::CMD_ENQ)
        ? (out_item_o.status != sqm_pkg::ST_UNDERFLOW)
        : (out_item_o.status != sqm_pkg::ST_OVERFLOW)))
    else $error("accepted item gave no fitting result");

endmodule

bind sorted_max_priority_queue_core sqm_checker u_sqm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
